// ----- rtl/core/lmph_pkg.sv -----
// ----------------------------------------------------------------------------
// lmph_pkg: shared types and constants of the level meter
// Level format, command and register codes, configuration bundle.
// ----------------------------------------------------------------------------
package lmph_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int LVL_W        = FRAC_BITS + 1;   // 0 .. full scale inclusive
    localparam int HOLD_W       = 11;
    localparam int HOLD_TICKS_W = 10;
    localparam int DB_W         = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 17;
    localparam int PROD_W       = 2 * LVL_W;

    typedef logic [LVL_W-1:0]  t_lvl;
    typedef logic [HOLD_W-1:0] t_hold;

    localparam t_lvl  FULL_SCALE = t_lvl'(1 << FRAC_BITS);
    localparam t_hold HOLD_MAX   = '1;

    // dB window in Q7.8: -60 dB .. +6 dB
    localparam logic signed [DB_W-1:0] DB_LOW  = -16'sd15360;
    localparam logic signed [DB_W-1:0] DB_HIGH = 16'sd1536;
    // (x*65536 + 8448) / 16896 == (x*256 + 33) / 66, done as a reciprocal multiply
    localparam int          DB_NUM_W   = 23;
    localparam logic [22:0] DB_RECIP   = 23'd8134408;   // ceil(2^29 / 66)
    localparam int          DB_SHIFT   = 29;
    localparam logic [22:0] DB_ROUND   = 23'd33;

    typedef enum logic [1:0] {
        CMD_SET_LEVEL = 2'd0,
        CMD_SET_DB    = 2'd1,
        CMD_TICK      = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOLD_ENABLE    = 3'd0,
        CFG_HOLD_TICKS     = 3'd1,
        CFG_DECAY_STEP     = 3'd2,
        CFG_SMOOTH_COEF    = 3'd3,
        CFG_CLIP_THRESHOLD = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic                    hold_enable;
        logic [HOLD_TICKS_W-1:0] hold_ticks;
        t_lvl                    decay_step;
        t_lvl                    smooth_coef;
        t_lvl                    clip_threshold;
    } t_cfg;

endpackage

// ----- rtl/core/level_meter_peak_hold.sv -----
// ----------------------------------------------------------------------------
// level_meter_peak_hold: audio level meter ballistics
// Peak hold with decay, one-pole smoothing and clip indication.
// ----------------------------------------------------------------------------
// Each input item is a command: set a normalised level (clamped to full scale
// 65536), set a level in dB (Q7.8, -60..+6 dB mapped linearly onto 0..full
// scale, rounded to nearest) or a display tick. Every item gives exactly one
// result item holding the meter state after the update. One item is taken per
// clock while the input does not stall; the item goes into the input register,
// then through the state update whose registers are the result register, and
// the result is valid once the update has taken it. The input stalls only
// while the input register holds an item and a result is waiting under stall.
// Configuration is written through its own always-ready port and should only
// change while no item is in flight.
// ----------------------------------------------------------------------------
module level_meter_peak_hold
    import lmph_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input item channel
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [1:0]             i_command,
    input  logic [LVL_W-1:0]       i_level_in,
    input  logic signed [DB_W-1:0] i_db_in,
    // result item channel
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [LVL_W-1:0]       o_level_out,
    output logic [LVL_W-1:0]       o_smooth_out,
    output logic [LVL_W-1:0]       o_peak_out,
    output logic                   o_clip_out,
    // configuration write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg cfg;
    t_cmd in_cmd;
    t_lvl in_level;

    logic r_in_vld,  n_in_vld;
    logic r_out_vld, n_out_vld;
    logic advance;     // state/result stage free to take an item
    logic fire;        // item moves from input register into the state update
    logic in_acc;

    // The state registers double as the result register: they only change on
    // fire, and fire only happens when the previous result has been taken.
    assign advance    = !r_out_vld || !i_out_stall;
    assign fire       = r_in_vld && advance;
    assign o_in_stall = r_in_vld && !advance;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign n_in_vld  = in_acc || (r_in_vld && !fire);
    assign n_out_vld = fire || (r_out_vld && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_out_valid = r_out_vld;

    lmph_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    lmph_in_stage u_in (
        .i_clk      (i_clk),
        .i_load     (in_acc),
        .i_command  (i_command),
        .i_level_in (i_level_in),
        .i_db_in    (i_db_in),
        .o_cmd      (in_cmd),
        .o_level    (in_level)
    );

    lmph_ballistics u_bal (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_cmd          (in_cmd),
        .i_level        (in_level),
        .i_cfg          (cfg),
        .o_level_now    (o_level_out),
        .o_level_smooth (o_smooth_out),
        .o_peak_marker  (o_peak_out),
        .o_clip_flag    (o_clip_out)
    );

endmodule

// ----- rtl/core/lmph_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// lmph_cfg_regs: configuration register file
// Five registers written by index, always ready.
// ----------------------------------------------------------------------------
module lmph_cfg_regs
    import lmph_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_cfg_ready,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg, n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_HOLD_ENABLE:    n_cfg.hold_enable    = i_cfg_data[0];
                CFG_HOLD_TICKS:     n_cfg.hold_ticks     = i_cfg_data[HOLD_TICKS_W-1:0];
                CFG_DECAY_STEP:     n_cfg.decay_step     = t_lvl'(i_cfg_data);
                CFG_SMOOTH_COEF:    n_cfg.smooth_coef    = t_lvl'(i_cfg_data);
                CFG_CLIP_THRESHOLD: n_cfg.clip_threshold = t_lvl'(i_cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_enable    <= 1'b1;
            r_cfg.hold_ticks     <= HOLD_TICKS_W'(57);
            r_cfg.decay_step     <= t_lvl'(350);
            r_cfg.smooth_coef    <= t_lvl'(19661);
            r_cfg.clip_threshold <= t_lvl'(62259);
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ----- rtl/core/lmph_in_stage.sv -----
// ----------------------------------------------------------------------------
// lmph_in_stage: input register with level conversion
// Clamps a normalised level or maps a dB value, then registers the item.
// ----------------------------------------------------------------------------
module lmph_in_stage
    import lmph_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_load,
    input  logic [1:0]             i_command,
    input  logic [LVL_W-1:0]       i_level_in,
    input  logic signed [DB_W-1:0] i_db_in,
    output t_cmd                   o_cmd,
    output t_lvl                   o_level
);

    t_cmd r_cmd;
    t_lvl r_level;
    t_lvl n_level;

    logic [DB_W-1:0]              db_ofs;
    logic [DB_NUM_W-1:0]          db_num;
    logic [2*DB_NUM_W-1:0]        db_prod;
    t_lvl                         db_level;

    always_comb begin
        db_ofs  = i_db_in - DB_LOW;
        db_num  = {db_ofs[DB_NUM_W-9:0], 8'h00} + DB_ROUND;
        db_prod = db_num * DB_RECIP;
        if (i_db_in <= DB_LOW) begin
            db_level = '0;
        end else if (i_db_in >= DB_HIGH) begin
            db_level = FULL_SCALE;
        end else begin
            db_level = db_prod[DB_SHIFT +: LVL_W];
        end
    end

    always_comb begin
        case (t_cmd'(i_command))
            CMD_SET_LEVEL: n_level = (i_level_in > FULL_SCALE) ? FULL_SCALE : i_level_in;
            CMD_SET_DB:    n_level = db_level;
            default:       n_level = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cmd   <= t_cmd'(i_command);
            r_level <= n_level;
        end
    end

    assign o_cmd   = r_cmd;
    assign o_level = r_level;

endmodule

// ----- rtl/core/lmph_ballistics.sv -----
// ----------------------------------------------------------------------------
// lmph_ballistics: meter state and its update
// Level set, smoothing, level and peak decay, hold count, clip flag.
// ----------------------------------------------------------------------------
module lmph_ballistics
    import lmph_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_fire,
    input  t_cmd  i_cmd,
    input  t_lvl  i_level,
    input  t_cfg  i_cfg,
    output t_lvl  o_level_now,
    output t_lvl  o_level_smooth,
    output t_lvl  o_peak_marker,
    output logic  o_clip_flag
);

    t_lvl  r_level_now,  n_level_now;
    t_lvl  r_level_smooth, n_level_smooth;
    t_lvl  r_peak_marker, n_peak_marker;
    t_lvl  r_peak_latched, n_peak_latched;
    t_hold r_hold_count, n_hold_count;
    logic  r_clip_flag, n_clip_flag;

    logic              up;
    t_lvl              diff;
    logic [PROD_W-1:0] prod;
    t_lvl              step;
    logic [LVL_W:0]    sum;
    t_lvl              smooth_t;
    t_lvl              level_t;
    t_hold             hold_t;
    logic              decay_on;
    t_lvl              peak_dec;
    logic              raise;

    // tick path
    always_comb begin
        up   = (r_level_now >= r_level_smooth);
        diff = up ? (r_level_now - r_level_smooth) : (r_level_smooth - r_level_now);
        prod = (PROD_W'(diff) * PROD_W'(i_cfg.smooth_coef))
             + PROD_W'(1 << (FRAC_BITS - 1));
        step = prod[FRAC_BITS +: LVL_W];
        sum  = {1'b0, r_level_smooth} + {1'b0, step};
        if (up) begin
            smooth_t = (sum > {1'b0, FULL_SCALE}) ? FULL_SCALE : sum[LVL_W-1:0];
        end else begin
            smooth_t = (r_level_smooth > step) ? (r_level_smooth - step) : '0;
        end

        level_t  = (r_level_now > i_cfg.decay_step) ? (r_level_now - i_cfg.decay_step) : '0;
        hold_t   = (r_hold_count != HOLD_MAX) ? (r_hold_count + t_hold'(1)) : r_hold_count;
        decay_on = i_cfg.hold_enable && (hold_t > t_hold'(i_cfg.hold_ticks));
        peak_dec = (r_peak_marker > i_cfg.decay_step) ?
                   (r_peak_marker - i_cfg.decay_step) : '0;
    end

    always_comb begin
        n_level_now    = r_level_now;
        n_level_smooth = r_level_smooth;
        n_peak_marker  = r_peak_marker;
        n_peak_latched = r_peak_latched;
        n_hold_count   = r_hold_count;
        n_clip_flag    = r_clip_flag;
        raise          = (i_level > r_peak_marker);
        if (i_fire) begin
            case (i_cmd)
                CMD_SET_LEVEL, CMD_SET_DB: begin
                    n_level_now = i_level;
                    if (raise) begin
                        n_peak_marker  = i_level;
                        n_peak_latched = i_level;
                        n_hold_count   = '0;
                    end
                    n_clip_flag = (n_peak_latched > i_cfg.clip_threshold);
                end
                CMD_TICK: begin
                    n_level_smooth = smooth_t;
                    n_level_now    = level_t;
                    n_hold_count   = hold_t;
                    if (decay_on) begin
                        n_peak_marker = (peak_dec < level_t) ? level_t : peak_dec;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_now    <= '0;
            r_level_smooth <= '0;
            r_peak_marker  <= '0;
            r_peak_latched <= '0;
            r_hold_count   <= '0;
            r_clip_flag    <= 1'b0;
        end else begin
            r_level_now    <= n_level_now;
            r_level_smooth <= n_level_smooth;
            r_peak_marker  <= n_peak_marker;
            r_peak_latched <= n_peak_latched;
            r_hold_count   <= n_hold_count;
            r_clip_flag    <= n_clip_flag;
        end
    end

    assign o_level_now    = r_level_now;
    assign o_level_smooth = r_level_smooth;
    assign o_peak_marker  = r_peak_marker;
    assign o_clip_flag    = r_clip_flag;

endmodule
